FILE: hw/rtl/sobs_pkg.sv
// shared constants for the shift-or byte search block
`default_nettype none

package sobs_pkg;

  localparam int unsigned VEC_W      = 32;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OFF_W      = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned REG_BYTES  = 8;

  typedef logic [VEC_W-1:0]      vec_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam vec_t VEC_RESET = 32'hffff_fffe;
  localparam vec_t VEC_ALL   = 32'hffff_ffff;

  // configuration register indexes
  localparam cfg_addr_t REG_NEEDLE_LOW    = 3'd0;
  localparam cfg_addr_t REG_NEEDLE_SECOND = 3'd1;
  localparam cfg_addr_t REG_NEEDLE_THIRD  = 3'd2;
  localparam cfg_addr_t REG_NEEDLE_HIGH   = 3'd3;
  localparam cfg_addr_t REG_NEEDLE_LENGTH = 3'd4;

endpackage

`default_nettype wire

FILE: hw/rtl/sobs_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none

module sobs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-edge write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/shift_or_byte_search.sv
// top level of the shift-or byte string search
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+-----------------------------------------
// in_     | in  | tvalid / tready    | tdata = text_byte, tlast = final_byte
// out_    | out | tvalid / tready    | tdata = match_offset, tuser = found
// cfg_    | in  | we (no wait)       | addr = register index, wdata = value
//
// one word per clock sustained while no result word is stalled: a word is
// accepted, the search state is read from the state ram in the same edge and
// the update is written back as the word leaves the compute stage (forwarded
// to a read on that edge); result words are registered after the compute stage
// reset (rst_n low, synchronous) empties the pipeline, clears the needle and
// marks the state ram entry invalid so it reads as the idle search state
// a stalled result holds the compute stage; one more word is still taken
`default_nettype none

module shift_or_byte_search #(
  parameter int unsigned MAX_NEEDLE   = 31,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input word channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // final_byte
  // result word channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [31:0] match_offset
  output logic             out_tuser,  // [0] found
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [63:0] cfg_wdata
);

  localparam int unsigned POS_W   = OFFSET_WIDTH;
  localparam int unsigned ST_W    = 1 + POS_W + sobs_pkg::VEC_W;
  localparam int unsigned RAM_D   = 2;
  localparam int unsigned RAM_AW  = $clog2(RAM_D);
  localparam int unsigned NDL_W   = MAX_NEEDLE * sobs_pkg::BYTE_W;

  localparam logic [RAM_AW-1:0] ST_ADDR = '0;

  // state word layout: {already_found, byte_position, match_vector}
  localparam logic [ST_W-1:0] ST_RESET = {1'b0, {POS_W{1'b0}}, sobs_pkg::VEC_RESET};

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [NDL_W-1:0]   needle_r;
  sobs_pkg::len_t     len_r;

  // each needle byte lives in register byte / 8, lane byte % 8
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_r <= '0;
    end else if (cfg_we) begin
      for (int b = 0; b < MAX_NEEDLE; b++) begin
        if (cfg_addr == sobs_pkg::REG_NEEDLE_LOW +
                        sobs_pkg::cfg_addr_t'(b / sobs_pkg::REG_BYTES)) begin
          needle_r[b*8 +: 8] <= cfg_wdata[(b % sobs_pkg::REG_BYTES)*8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_we && cfg_addr == sobs_pkg::REG_NEEDLE_LENGTH) begin
      len_r <= cfg_wdata[sobs_pkg::LEN_W-1:0];
    end
  end

  // lengths beyond the stored needle saturate
  sobs_pkg::len_t len_eff;
  assign len_eff = (len_r > sobs_pkg::len_t'(MAX_NEEDLE)) ?
                   sobs_pkg::len_t'(MAX_NEEDLE) : len_r;

  // ------------------------------------------------------------------
  // handshake and compute stage
  // ------------------------------------------------------------------
  logic                s1_vld_r;
  logic [7:0]          s1_byte_r;
  logic                s1_last_r;
  logic                fwd_sel_r;
  logic [ST_W-1:0]     fwd_r;
  logic                ent_vld_r;
  logic                out_tvalid_r;
  logic                out_found_r;
  logic [31:0]         out_off_r;

  logic                in_acc;
  logic                s1_go;

  assign s1_go     = s1_vld_r && (!out_tvalid_r || out_tready);
  assign in_tready = !s1_vld_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  // state ram: one entry holds the running search
  logic [ST_W-1:0] ram_rdata;
  logic [ST_W-1:0] st_nxt;

  sobs_ram #(
    .WIDTH (ST_W),
    .DEPTH (RAM_D)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (ST_ADDR),
    .wdata (st_nxt),
    .re    (in_acc),
    .raddr (ST_ADDR),
    .rdata (ram_rdata)
  );

  // current state: forward the write that landed on the read edge
  logic [ST_W-1:0]      st_cur;
  sobs_pkg::vec_t       vec_cur;
  logic [POS_W-1:0]     pos_cur;
  logic                 found_cur;

  always_comb begin
    if (fwd_sel_r) begin
      st_cur = fwd_r;
    end else if (ent_vld_r) begin
      st_cur = ram_rdata;
    end else begin
      st_cur = ST_RESET;
    end
  end

  assign vec_cur   = st_cur[sobs_pkg::VEC_W-1:0];
  assign pos_cur   = st_cur[sobs_pkg::VEC_W +: POS_W];
  assign found_cur = st_cur[ST_W-1];

  // parallel compare of the text byte against every needle byte
  sobs_pkg::vec_t mask;
  always_comb begin
    mask = sobs_pkg::VEC_ALL;
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      if (sobs_pkg::len_t'(i) < len_eff && needle_r[i*8 +: 8] == s1_byte_r) begin
        mask[i] = 1'b0;
      end
    end
  end

  // position viewed as a 32-bit offset
  logic [31:0] pos32;
  if (POS_W >= 32) begin : g_pos_trunc
    assign pos32 = pos_cur[31:0];
  end else begin : g_pos_ext
    assign pos32 = {{(32-POS_W){1'b0}}, pos_cur};
  end

  sobs_pkg::vec_t   vec_upd;
  logic [31:0]      off_match;
  logic [POS_W-1:0] pos_inc;
  logic             res_vld;
  logic             res_found;
  logic [31:0]      res_off;

  assign vec_upd   = (vec_cur | mask) << 1;
  assign off_match = pos32 - 32'(len_eff) + 32'd1;
  assign pos_inc   = (pos_cur == {POS_W{1'b1}}) ? pos_cur : pos_cur + POS_W'(1);

  always_comb begin
    sobs_pkg::vec_t vec_n;
    logic           found_n;
    vec_n     = vec_cur;
    found_n   = found_cur;
    res_vld   = 1'b0;
    res_found = 1'b0;
    res_off   = '0;
    if (!found_cur) begin
      if (len_eff == '0) begin
        // empty needle matches at the first byte
        found_n   = 1'b1;
        res_vld   = 1'b1;
        res_found = 1'b1;
      end else begin
        vec_n = vec_upd;
        if (!vec_upd[len_eff]) begin
          found_n   = 1'b1;
          res_vld   = 1'b1;
          res_found = 1'b1;
          res_off   = off_match;
        end
      end
    end
    if (s1_last_r) begin
      // end of haystack: report a miss if nothing was found, then start over
      if (!found_n) begin
        res_vld = 1'b1;
      end
      st_nxt = ST_RESET;
    end else begin
      st_nxt = {found_n, pos_inc, vec_n};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      fwd_sel_r    <= 1'b0;
      ent_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r  <= 1'b1;
        fwd_sel_r <= s1_go;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_go) begin
        ent_vld_r <= 1'b1;
      end
      if (s1_go && res_vld) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_go) begin
      fwd_r <= st_nxt;
    end
    if (s1_go && res_vld) begin
      out_found_r <= res_found;
      out_off_r   <= res_off;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_off_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sobs_chk.sv
// port-level checker for the shift-or byte search, bound to the top level
`default_nettype none

module sobs_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // a miss always carries a zero offset
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready || out_tvalid |-> out_tuser || out_tdata == 32'd0)
    else $error("not-found result with nonzero offset");

  // a fresh result follows an accepted input word
  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result appeared without a preceding input word");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind shift_or_byte_search sobs_chk u_sobs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
